// ----- rtl/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// shared types and constants of the first-fit block allocator
// ----------------------------------------------------------------------------
`default_nettype none
package ffba_pkg;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_BADADDR = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_LOAD    = 4'd1,
        OP_RD_CUR  = 4'd2,
        OP_ALLOC   = 4'd3,
        OP_STEP    = 4'd4,
        OP_FREE    = 4'd5,
        OP_RD_NXT  = 4'd6,
        OP_MERGE_N = 4'd7,
        OP_PRV_RST = 4'd8,
        OP_MERGE_P = 4'd9,
        OP_CLR     = 4'd10,
        OP_SPLIT   = 4'd11
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic bad;      // request rejected or zero size
        logic scan_end; // scan ran off the heap
        logic fit;      // current segment fits
        logic split;    // fit leaves a remainder
        logic nxt_ok;   // next segment exists
        logic nxt_mrg;  // next segment is free
        logic prv_hit;  // walk reached segment before header
        logic prv_mrg;  // that segment is free
        logic prv_end;  // walk reached header without hit
        logic hdr_used; // header block starts an allocated segment
    } stat_t;
endpackage
`default_nettype wire

// ----- rtl/ffba_datapath.sv -----
// ----------------------------------------------------------------------------
// ffba_datapath
// block stores, scan pointers and segment arithmetic
// ----------------------------------------------------------------------------
`default_nettype none
module ffba_datapath #(
    parameter int HEAP_BLOCKS = 4096,
    parameter int BLOCK_BYTES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  ffba_pkg::cmd_t         cmd,
    input  wire logic              in_mode,
    input  wire logic [31:0]       in_size,
    input  wire logic [31:0]       in_off,
    output ffba_pkg::stat_t        stat,
    output logic [17:0]            res_off
);
    localparam int AW = (HEAP_BLOCKS > 1) ? $clog2(HEAP_BLOCKS) : 1;
    localparam int LW = $clog2(HEAP_BLOCKS + 1);
    localparam int PW = AW + 1;
    localparam int BS = $clog2(BLOCK_BYTES);
    localparam logic [PW-1:0] HB = PW'(HEAP_BLOCKS);

    // memory: head/free per entry, length separate
    logic [1:0]    hf_mem [HEAP_BLOCKS];
    logic [LW-1:0] len_mem [HEAP_BLOCKS];

    logic [PW-1:0] blk_reg, blk_next;
    logic [PW-1:0] hdr_reg;
    logic [PW-1:0] nxt_reg;
    logic [32:0]   need_reg;
    logic          bad_reg;
    logic          rd_h, rd_f;
    logic [LW-1:0] rd_len;
    logic [LW-1:0] hlen_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] clr_reg;
    logic          clr_done_reg;
    logic [PW-1:0] step_w;

    logic [31-BS:0] q;
    logic           rmd;
    assign q   = in_size[31:BS];
    assign rmd = |in_size[BS-1:0];

    assign step_w = (rd_len == '0) ? PW'(1) : PW'(rd_len);

    // read address: next segment, header while the walk pointer rewinds, else walk pointer
    always_comb
    begin
        unique case (cmd.op)
            ffba_pkg::OP_RD_NXT:  rd_addr = nxt_reg[AW-1:0];
            ffba_pkg::OP_PRV_RST: rd_addr = hdr_reg[AW-1:0];
            default:              rd_addr = blk_reg[AW-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        {rd_h, rd_f} <= hf_mem[rd_addr];
        rd_len       <= len_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (cmd.op == ffba_pkg::OP_CLR && !clr_done_reg)
        begin
            clr_reg <= clr_reg + AW'(1);
            if (clr_reg == AW'(HEAP_BLOCKS - 1))
                clr_done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            ffba_pkg::OP_CLR:
            begin
                hf_mem[clr_reg]  <= (clr_reg == '0) ? 2'b11 : 2'b00;
                len_mem[clr_reg] <= (clr_reg == '0) ? LW'(HEAP_BLOCKS) : '0;
            end
            ffba_pkg::OP_ALLOC:
            begin
                hf_mem[blk_reg[AW-1:0]]  <= 2'b10;
                len_mem[blk_reg[AW-1:0]] <= LW'(need_reg);
            end
            ffba_pkg::OP_SPLIT:
            begin
                hf_mem[AW'(blk_reg + PW'(need_reg))]  <= 2'b11;
                len_mem[AW'(blk_reg + PW'(need_reg))] <= LW'(hlen_reg - LW'(need_reg));
            end
            ffba_pkg::OP_FREE:
                hf_mem[hdr_reg[AW-1:0]] <= 2'b11;
            ffba_pkg::OP_MERGE_N:
            begin
                hf_mem[nxt_reg[AW-1:0]]  <= 2'b00;
                len_mem[hdr_reg[AW-1:0]] <= hlen_reg + rd_len;
            end
            ffba_pkg::OP_MERGE_P:
            begin
                hf_mem[hdr_reg[AW-1:0]]  <= 2'b00;
                len_mem[blk_reg[AW-1:0]] <= rd_len + hlen_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        blk_next = blk_reg;
        unique case (cmd.op)
            ffba_pkg::OP_LOAD:    blk_next = '0;
            ffba_pkg::OP_STEP:    blk_next = blk_reg + step_w;
            ffba_pkg::OP_PRV_RST: blk_next = '0;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            blk_reg <= '0;
        else
            blk_reg <= blk_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            ffba_pkg::OP_LOAD:
            begin
                need_reg <= 33'(q) + 33'd1 + 33'(rmd);
                hdr_reg  <= PW'(in_off[31:BS] - 1'b1);
                if (in_mode == ffba_pkg::MODE_ALLOC)
                    bad_reg <= (in_size == '0);
                else
                    bad_reg <= (in_off[31:BS] == '0) || (|in_off[BS-1:0])
                             || (in_off[31:BS] > (32-BS)'(HEAP_BLOCKS));
            end
            ffba_pkg::OP_RD_CUR:  hlen_reg <= rd_len;
            ffba_pkg::OP_FREE:
            begin
                nxt_reg  <= hdr_reg + step_w;
                hlen_reg <= rd_len;
            end
            ffba_pkg::OP_MERGE_N: hlen_reg <= hlen_reg + rd_len;
            default: ;
        endcase
    end

    always_comb
    begin
        stat.clr_done = clr_done_reg;
        stat.bad      = bad_reg;
        stat.scan_end = (blk_reg >= HB);
        stat.fit      = rd_h && rd_f && (33'(rd_len) >= need_reg);
        stat.split    = (33'(rd_len) > need_reg);
        stat.nxt_ok   = (nxt_reg < HB);
        stat.nxt_mrg  = rd_h && rd_f;
        stat.prv_hit  = (blk_reg + step_w == hdr_reg);
        stat.prv_mrg  = rd_h && rd_f;
        stat.prv_end  = (blk_reg >= hdr_reg);
        stat.hdr_used = rd_h && !rd_f;
    end

    assign res_off = 18'(blk_reg + PW'(1)) << BS;
endmodule
`default_nettype wire

// ----- rtl/ffba_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffba_ctrl
// request sequencer of the first-fit block allocator
// ----------------------------------------------------------------------------
`default_nettype none
module ffba_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        in_mode,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  ffba_pkg::stat_t  stat,
    output ffba_pkg::cmd_t   cmd,
    output logic [1:0]       res_status,
    output logic             res_use_off
);
    typedef enum logic [13:0] {
        S_CLR   = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_CHK   = 14'b00000000000100,
        S_ARD   = 14'b00000000001000,
        S_AEV   = 14'b00000000010000,
        S_ASPL  = 14'b00000000100000,
        S_FRD   = 14'b00000001000000,
        S_FEV   = 14'b00000010000000,
        S_NRD   = 14'b00000100000000,
        S_NEV   = 14'b00001000000000,
        S_PRD   = 14'b00010000000000,
        S_PEV   = 14'b00100000000000,
        S_DONE  = 14'b01000000000000,
        S_AWR   = 14'b10000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic       mode_reg, mode_next;
    logic [1:0] st_reg, st_next;
    logic       uo_reg, uo_next;
    logic       split_reg, split_next;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_DONE);
    assign res_status  = st_reg;
    assign res_use_off = uo_reg;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        st_next    = st_reg;
        uo_next    = uo_reg;
        split_next = split_reg;
        cmd.op     = ffba_pkg::OP_NONE;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.op = ffba_pkg::OP_CLR;
                if (stat.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
                if (in_valid)
                begin
                    cmd.op     = ffba_pkg::OP_LOAD;
                    mode_next  = in_mode;
                    state_next = S_CHK;
                end
            S_CHK:
            begin
                uo_next = 1'b0;
                if (mode_reg == ffba_pkg::MODE_ALLOC)
                begin
                    st_next    = ffba_pkg::ST_NOMEM;
                    state_next = stat.bad ? S_DONE : S_ARD;
                end
                else
                begin
                    st_next    = ffba_pkg::ST_BADADDR;
                    state_next = stat.bad ? S_DONE : S_FRD;
                end
            end
            S_ARD:
                if (stat.scan_end)
                    state_next = S_DONE;
                else
                    state_next = S_AEV;
            S_AEV:
                if (stat.fit)
                begin
                    cmd.op     = ffba_pkg::OP_RD_CUR;
                    split_next = stat.split;
                    state_next = S_AWR;
                end
                else
                begin
                    cmd.op     = ffba_pkg::OP_STEP;
                    state_next = S_ARD;
                end
            S_AWR:
            begin
                cmd.op     = ffba_pkg::OP_ALLOC;
                st_next    = ffba_pkg::ST_OK;
                uo_next    = 1'b1;
                state_next = split_reg ? S_ASPL : S_DONE;
            end
            S_ASPL:
            begin
                cmd.op     = ffba_pkg::OP_SPLIT;
                state_next = S_DONE;
            end
            S_FRD:
            begin
                cmd.op     = ffba_pkg::OP_PRV_RST;
                state_next = S_FEV;
            end
            S_FEV:
                if (stat.hdr_used)
                begin
                    cmd.op     = ffba_pkg::OP_FREE;
                    st_next    = ffba_pkg::ST_OK;
                    state_next = S_NRD;
                end
                else
                    state_next = S_DONE;
            S_NRD:
            begin
                cmd.op     = ffba_pkg::OP_RD_NXT;
                state_next = S_NEV;
            end
            S_NEV:
            begin
                if (stat.nxt_ok && stat.nxt_mrg)
                    cmd.op = ffba_pkg::OP_MERGE_N;
                state_next = S_PRD;
            end
            S_PRD:
                if (stat.prv_end)
                    state_next = S_DONE;
                else
                    state_next = S_PEV;
            S_PEV:
                if (stat.prv_hit)
                begin
                    if (stat.prv_mrg)
                        cmd.op = ffba_pkg::OP_MERGE_P;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = ffba_pkg::OP_STEP;
                    state_next = S_PRD;
                end
            S_DONE:
                if (out_ready)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            mode_reg  <= 1'b0;
            st_reg    <= ffba_pkg::ST_OK;
            uo_reg    <= 1'b0;
            split_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            st_reg    <= st_next;
            uo_reg    <= uo_next;
            split_reg <= split_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/first_fit_block_allocator_top.sv -----
// allocate scans segments from the heap start, with an extra write on a split;
// free walks the segments before the header; a rejected request skips the scan
// one request at a time, next accepted the cycle after the result transaction
// after reset a clearing pass over all HEAP_BLOCKS blocks runs before in_ready
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// first-fit block heap allocator with coalescing on free
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_block_allocator_top #(
    parameter int HEAP_BLOCKS = 4096,
    parameter int BLOCK_BYTES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        mode,
    input  wire logic [31:0] alloc_size,
    input  wire logic [31:0] free_offset,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [17:0]      payload_offset,
    output logic [1:0]       status
);
    ffba_pkg::cmd_t  cmd;
    ffba_pkg::stat_t stat;
    logic [17:0]     dp_off;
    logic [1:0]      st;
    logic            use_off;
    logic [17:0]     off_reg;

    ffba_datapath #(.HEAP_BLOCKS(HEAP_BLOCKS), .BLOCK_BYTES(BLOCK_BYTES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_mode(mode),
        .in_size(alloc_size), .in_off(free_offset), .stat(stat), .res_off(dp_off)
    );

    ffba_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_mode(mode), .out_valid(out_valid), .out_ready(out_ready),
        .stat(stat), .cmd(cmd), .res_status(st), .res_use_off(use_off)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.op == ffba_pkg::OP_ALLOC)
            off_reg <= dp_off;
    end

    assign payload_offset = use_off ? off_reg : 18'd0;
    assign status         = st;
endmodule
`default_nettype wire

// ----- rtl/ffba_checker.sv -----
// ----------------------------------------------------------------------------
// ffba_checker
// port-level checks of the allocator
// ----------------------------------------------------------------------------
`default_nettype none
module ffba_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [17:0] payload_offset,
    input wire logic [1:0]  status
);
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ffba_pkg::ST_OK |-> payload_offset == 18'd0)
        else $error("nonzero offset on failure");
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3) else $error("bad status code");
    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("second transaction taken");
endmodule

bind first_fit_block_allocator_top ffba_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .payload_offset(payload_offset), .status(status)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// drives allocate and free requests into the first-fit block allocator and
// compares every response with a behavioural heap kept alongside it
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    localparam int NBLK = 4096;
    localparam int BB = 64;
    localparam int N_RAND = 1630;
    localparam int WD_LIMIT = 200000;

    logic clk, rst_n;
    logic in_valid, in_ready, mode, out_valid, out_ready;
    logic [31:0] alloc_size, free_offset;
    logic [17:0] payload_offset;
    logic [1:0] status;

    first_fit_block_allocator_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .alloc_size(alloc_size), .free_offset(free_offset),
        .out_valid(out_valid), .out_ready(out_ready),
        .payload_offset(payload_offset), .status(status)
    );

    typedef struct {
        logic [17:0] off;
        logic [1:0] st;
    } resp_t;

    typedef struct {
        logic m;
        logic [31:0] sz;
        logic [31:0] fo;
        logic chk;
        logic [17:0] off;
        logic [1:0] st;
    } row_t;

    bit heap_head[NBLK];
    bit heap_free[NBLK];
    int unsigned heap_len[NBLK];
    resp_t resp_q[$];
    int unsigned live_q[$];
    int errors, n_sent, n_rcvd, n_alloc_ok, n_free_ok, n_bad, n_nomem;
    int idle_cyc;
    bit quiet, hold_rx, done;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned blk_step(int unsigned b);
        return heap_len[b] == 0 ? 1 : heap_len[b];
    endfunction

    function automatic resp_t heap_request(logic m, logic [31:0] sz, logic [31:0] fo);
        resp_t r;
        longint unsigned need, b, len, hdr, nxt, prv, aft;
        r.off = '0;
        if (m == ffba_pkg::MODE_ALLOC)
        begin
            r.st = ffba_pkg::ST_NOMEM;
            if (sz == 0) return r;
            need = sz / BB + 1 + ((sz % BB) != 0 ? 1 : 0);
            for (b = 0; b < NBLK; b += blk_step(b))
            begin
                len = heap_len[b];
                if (!heap_head[b] || !heap_free[b] || len < need) continue;
                if (len > need)
                begin
                    heap_head[b + need] = 1;
                    heap_free[b + need] = 1;
                    heap_len[b + need] = len - need;
                end
                heap_free[b] = 0;
                heap_len[b] = need;
                r.off = 18'(((b + 1) * BB));
                r.st = ffba_pkg::ST_OK;
                return r;
            end
            return r;
        end
        r.st = ffba_pkg::ST_BADADDR;
        if (fo < BB || (fo % BB) != 0) return r;
        hdr = fo / BB - 1;
        if (hdr >= NBLK) return r;
        if (!heap_head[hdr] || heap_free[hdr]) return r;
        heap_free[hdr] = 1;
        r.st = ffba_pkg::ST_OK;
        nxt = hdr + blk_step(hdr);
        if (nxt < NBLK && heap_head[nxt] && heap_free[nxt])
        begin
            heap_len[hdr] += heap_len[nxt];
            heap_head[nxt] = 0;
            heap_free[nxt] = 0;
        end
        prv = 0;
        while (prv < hdr)
        begin
            aft = prv + blk_step(prv);
            if (aft == hdr)
            begin
                if (heap_head[prv] && heap_free[prv])
                begin
                    heap_len[prv] += heap_len[hdr];
                    heap_head[hdr] = 0;
                    heap_free[hdr] = 0;
                end
                break;
            end
            prv = aft;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch on response %0d: %s got %0d expected %0d", n_rcvd, what, got, want);
        errors++;
    endtask

    task automatic send(logic m, logic [31:0] sz, logic [31:0] fo, logic chk,
                        logic [17:0] off, logic [1:0] st);
        resp_t r;
        while (!quiet && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        mode <= m;
        alloc_size <= sz;
        free_offset <= fo;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        r = heap_request(m, sz, fo);
        if (chk)
        begin
            if (r.off !== off) report_mismatch("table offset", 32'(r.off), 32'(off));
            if (r.st !== st) report_mismatch("table status", 32'(r.st), 32'(st));
        end
        if (m == ffba_pkg::MODE_ALLOC && r.st == ffba_pkg::ST_OK) live_q.push_back(32'(r.off));
        resp_q.push_back(r);
        n_sent++;
    endtask

    // receiver side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                n_rcvd++;
                if (resp_q.size() == 0)
                begin
                    report_mismatch("unexpected response status", 32'(status), 32'd0);
                end
                else
                begin
                    resp_t e;
                    e = resp_q.pop_front();
                    if (payload_offset !== e.off)
                        report_mismatch("payload_offset", 32'(payload_offset), 32'(e.off));
                    if (status !== e.st)
                        report_mismatch("status", 32'(status), 32'(e.st));
                    case (e.st)
                        ffba_pkg::ST_OK: if (e.off != 0) n_alloc_ok++; else n_free_ok++;
                        ffba_pkg::ST_NOMEM: n_nomem++;
                        default: n_bad++;
                    endcase
                end
            end
            out_ready <= !hold_rx && (quiet || $urandom_range(99) >= 16);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n && !done)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cyc <= 0;
            else idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= WD_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    row_t dir[$];

    initial
    begin
        int unsigned k, pick;
        logic [31:0] v;
        row_t rw;
        rst_n = 0; in_valid = 0; mode = ffba_pkg::MODE_ALLOC;
        alloc_size = '0; free_offset = '0; out_ready = 0;
        errors = 0; n_sent = 0; n_rcvd = 0; idle_cyc = 0;
        n_alloc_ok = 0; n_free_ok = 0; n_bad = 0; n_nomem = 0;
        quiet = 0; hold_rx = 0; done = 0;
        for (int i = 0; i < NBLK; i++)
        begin
            heap_head[i] = 0; heap_free[i] = 0; heap_len[i] = 0;
        end
        heap_head[0] = 1; heap_free[0] = 1; heap_len[0] = NBLK;
        repeat (9) @(posedge clk);
        rst_n <= 1;

        // m, size, offset, check, offset, status
        dir = '{
            '{ffba_pkg::MODE_ALLOC, 32'd0,         32'd0,         1, 18'd0,   ffba_pkg::ST_NOMEM},
            '{ffba_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 32'd0,         1, 18'd0,   ffba_pkg::ST_NOMEM},
            '{ffba_pkg::MODE_ALLOC, 32'd262144,    32'd0,         1, 18'd0,   ffba_pkg::ST_NOMEM},
            '{ffba_pkg::MODE_FREE,  32'd0,         32'd64,        1, 18'd0,   ffba_pkg::ST_BADADDR},
            '{ffba_pkg::MODE_ALLOC, 32'd1,         32'd0,         1, 18'd64,  ffba_pkg::ST_OK},
            '{ffba_pkg::MODE_ALLOC, 32'd64,        32'hFFFF_FFFF, 1, 18'd192, ffba_pkg::ST_OK},
            '{ffba_pkg::MODE_ALLOC, 32'd65,        32'd0,         1, 18'd320, ffba_pkg::ST_OK},
            '{ffba_pkg::MODE_FREE,  32'd0,         32'd0,         1, 18'd0,   ffba_pkg::ST_BADADDR},
            '{ffba_pkg::MODE_FREE,  32'd0,         32'd63,        1, 18'd0,   ffba_pkg::ST_BADADDR},
            '{ffba_pkg::MODE_FREE,  32'd0,         32'd100,       1, 18'd0,   ffba_pkg::ST_BADADDR},
            '{ffba_pkg::MODE_FREE,  32'd0,         32'd262208,    1, 18'd0,   ffba_pkg::ST_BADADDR},
            '{ffba_pkg::MODE_FREE,  32'hFFFF_FFFF, 32'hFFFF_FFC0, 1, 18'd0,   ffba_pkg::ST_BADADDR},
            '{ffba_pkg::MODE_FREE,  32'd0,         32'd128,       1, 18'd0,   ffba_pkg::ST_BADADDR},
            '{ffba_pkg::MODE_FREE,  32'd0,         32'd192,       1, 18'd0,   ffba_pkg::ST_OK},
            '{ffba_pkg::MODE_FREE,  32'd0,         32'd192,       1, 18'd0,   ffba_pkg::ST_BADADDR},
            '{ffba_pkg::MODE_FREE,  32'd0,         32'd64,        0, 18'd0,   ffba_pkg::ST_OK},
            '{ffba_pkg::MODE_FREE,  32'd0,         32'd320,       0, 18'd0,   ffba_pkg::ST_OK},
            '{ffba_pkg::MODE_ALLOC, 32'd262080,    32'd0,         1, 18'd64,  ffba_pkg::ST_OK},
            '{ffba_pkg::MODE_ALLOC, 32'd1,         32'd0,         1, 18'd0,   ffba_pkg::ST_NOMEM},
            '{ffba_pkg::MODE_FREE,  32'd0,         32'd64,        1, 18'd0,   ffba_pkg::ST_OK},
            '{ffba_pkg::MODE_ALLOC, 32'd128,       32'd0,         0, 18'd0,   ffba_pkg::ST_OK},
            '{ffba_pkg::MODE_ALLOC, 32'd262016,    32'd0,         0, 18'd0,   ffba_pkg::ST_OK}
        };
        quiet = 1;
        foreach (dir[i])
        begin
            rw = dir[i];
            send(rw.m, rw.sz, rw.fo, rw.chk, rw.off, rw.st);
        end
        while (live_q.size() > 0)
        begin
            send(ffba_pkg::MODE_FREE, $urandom, live_q.pop_front(), 0, '0, ffba_pkg::ST_OK);
        end
        quiet = 0;

        for (k = 0; k < N_RAND; k++)
        begin
            quiet = (k >= 600 && k < 800);
            if (k == 300) fork
                begin
                    hold_rx = 1;
                    repeat (3000) @(posedge clk);
                    hold_rx = 0;
                end
            join_none
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                case ($urandom_range(9))
                    0: v = $urandom;
                    1: v = $urandom_range(1, 65535);
                    2: v = 32'd64 * $urandom_range(1, 16);
                    default: v = $urandom_range(1, 2000);
                endcase
                send(ffba_pkg::MODE_ALLOC, v, $urandom, 0, '0, ffba_pkg::ST_OK);
            end
            else if (pick < 88 && live_q.size() > 0)
            begin
                int unsigned j;
                j = $urandom_range(live_q.size() - 1);
                v = live_q[j];
                live_q.delete(j);
                send(ffba_pkg::MODE_FREE, $urandom, v, 0, '0, ffba_pkg::ST_OK);
            end
            else
            begin
                case ($urandom_range(3))
                    0: v = $urandom;
                    1: v = 32'd64 * $urandom_range(0, 4200);
                    2: v = live_q.size() > 0 ? live_q[0] + 32'($urandom_range(1, 63)) : 32'd1;
                    default: v = 32'd64 * $urandom_range(1, 4096);
                endcase
                // stale offsets may hit a freed segment; predictor sorts it out
                send(ffba_pkg::MODE_FREE, $urandom, v, 0, '0, ffba_pkg::ST_OK);
                for (int j = 0; j < live_q.size(); j++)
                    if (live_q[j] == v && !heap_head[v / BB - 1]) live_q.delete(j);
            end
        end
        in_valid <= 1'b0;

        while (resp_q.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
        done = 1;
        $display("%0d requests: %0d allocations, %0d frees accepted, %0d out of memory,",
                 n_sent, n_alloc_ok, n_free_ok, n_nomem);
        $display("%0d rejected frees, one long output stall", n_bad);
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
